FILE: rtl/bsde_pkg.sv
`default_nettype none

package bsde_pkg;

   // grid size range and default
   localparam int GRID_SIZE_DEF = 32;
   localparam int GRID_MAX      = 64;

   // row and column positions, wide enough for a start plus an extent
   localparam int POS_W = 7;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // field widths of one request word
   localparam int OP_W  = 3;
   localparam int RC_W  = 5;
   localparam int EXT_W = 6;

   // operation codes
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
   localparam logic [OP_W-1:0] OP_VLINE = 3'd1;
   localparam logic [OP_W-1:0] OP_HLINE = 3'd2;
   localparam logic [OP_W-1:0] OP_RECT  = 3'd3;
   localparam logic [OP_W-1:0] OP_FILL  = 3'd4;
   localparam logic [OP_W-1:0] OP_READ  = 3'd5;

   typedef enum logic [1:0] {
      KIND_NOP,
      KIND_CLEAR,
      KIND_DRAW,
      KIND_READ
   } kind_type;

   // one classified command, rows [row_lo, row_end) are touched
   typedef struct packed {
      kind_type                kind;
      logic [POS_W-1:0]        row_lo;
      logic [POS_W-1:0]        row_end;
      logic [POS_W-1:0]        row_last;
      logic [GRID_MAX-1:0]     edge_set;
      logic [GRID_MAX-1:0]     mid_set;
      logic [GRID_MAX-1:0]     mid_clr;
      logic                    clip;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_READ  = 4'b1000
   } state_type;

   // bits j with lo <= j < hi
   function automatic logic [GRID_MAX-1:0] range_mask(input logic [POS_W-1:0] lo,
                                                      input logic [POS_W-1:0] hi);
      logic [GRID_MAX-1:0] m;
      for (int j = 0; j < GRID_MAX; j++) begin
         m[j] = (POS_W'(j) >= lo) && (POS_W'(j) < hi);
      end
      return m;
   endfunction

   function automatic logic [POS_W-1:0] pos_min(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/bsde_ram.sv
`default_nettype none

module bsde_ram
   import bsde_pkg::*;
#(
   parameter int WIDTH = GRID_SIZE_DEF,
   parameter int DEPTH = GRID_SIZE_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/bsde_front.sv
`default_nettype none

module bsde_front
   import bsde_pkg::*;
#(
   parameter int GRID_SIZE = GRID_SIZE_DEF
) (
   input  wire logic [OP_W-1:0]  operation,
   input  wire logic [RC_W-1:0]  start_row,
   input  wire logic [RC_W-1:0]  start_col,
   input  wire logic [EXT_W-1:0] length,
   input  wire logic [EXT_W-1:0] width,
   input  wire logic [EXT_W-1:0] height,
   output      cmd_type          cmd
);

   localparam logic [POS_W-1:0] LIM = POS_W'(GRID_SIZE);

   logic [POS_W-1:0] row_p;
   logic [POS_W-1:0] col_p;
   logic [POS_W-1:0] len_p;
   logic [POS_W-1:0] w_p;
   logic [POS_W-1:0] h_p;
   logic [POS_W-1:0] row_len_end;
   logic [POS_W-1:0] col_len_end;
   logic [POS_W-1:0] row_h_end;
   logic [POS_W-1:0] col_w_end;
   logic [GRID_MAX-1:0] box_mask;
   logic [GRID_MAX-1:0] side_mask;

   assign row_p       = POS_W'(start_row);
   assign col_p       = POS_W'(start_col);
   assign len_p       = POS_W'(length);
   assign w_p         = POS_W'(width);
   assign h_p         = POS_W'(height);
   assign row_len_end = row_p + len_p;
   assign col_len_end = col_p + len_p;
   assign row_h_end   = row_p + h_p;
   assign col_w_end   = col_p + w_p;
   assign box_mask    = range_mask(col_p, col_w_end);
   assign side_mask   = range_mask(col_p, col_p + POS_W'(1))
                      | range_mask(col_w_end - POS_W'(1), col_w_end);

   always_comb begin
      cmd          = '0;
      cmd.kind     = KIND_NOP;
      cmd.row_lo   = row_p;
      cmd.row_end  = row_p;
      cmd.row_last = row_p;
      unique case (operation)
         OP_CLEAR: begin
            cmd.kind = KIND_CLEAR;
         end
         OP_VLINE: begin
            cmd.kind = KIND_DRAW;
            if (length != '0) begin
               cmd.row_end  = pos_min(row_len_end, LIM);
               cmd.edge_set = range_mask(col_p, col_p + POS_W'(1));
               cmd.mid_set  = cmd.edge_set;
               cmd.clip     = (col_p >= LIM) || (row_len_end > LIM);
            end
         end
         OP_HLINE: begin
            cmd.kind = KIND_DRAW;
            if (length != '0) begin
               cmd.row_end  = (row_p < LIM) ? row_p + POS_W'(1) : row_p;
               cmd.edge_set = range_mask(col_p, col_len_end);
               cmd.mid_set  = cmd.edge_set;
               cmd.clip     = (row_p >= LIM) || (col_len_end > LIM);
            end
         end
         OP_RECT, OP_FILL: begin
            cmd.kind = KIND_DRAW;
            if ((width != '0) && (height != '0)) begin
               cmd.row_end  = pos_min(row_h_end, LIM);
               cmd.row_last = row_h_end - POS_W'(1);
               cmd.edge_set = box_mask;
               if (operation == OP_FILL) begin
                  cmd.mid_set = box_mask;
               end else begin
                  // outline: side columns set, interior cleared
                  cmd.mid_set = side_mask;
                  cmd.mid_clr = box_mask & ~side_mask;
               end
               cmd.clip = (row_h_end > LIM) || (col_w_end > LIM);
            end
         end
         OP_READ: begin
            cmd.kind     = KIND_READ;
            cmd.edge_set = range_mask(col_p, col_p + POS_W'(1));
            cmd.clip     = (row_p >= LIM) || (col_p >= LIM);
         end
         default: begin
            cmd.kind = KIND_NOP;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/bsde_queue.sv
`default_nettype none

module bsde_queue
   import bsde_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output      logic    full,
   input  wire logic    pop,
   output      logic    valid,
   output      cmd_type head_cmd
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign head_cmd = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/bsde_back.sv
`default_nettype none

module bsde_back
   import bsde_pkg::*;
#(
   parameter int GRID_SIZE = GRID_SIZE_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd,
   output      logic    cmd_pop,
   input  wire logic    rsp_ready,
   output      logic    rsp_valid,
   output      logic    rsp_pixel,
   output      logic    rsp_clip
);

   localparam int AW = $clog2(GRID_SIZE);

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [POS_W-1:0]     cur_ff, cur_in;
   logic                 pipe_vld_ff, pipe_vld_in;
   logic [AW-1:0]        pipe_row_ff, pipe_row_in;
   logic                 pipe_edge_ff, pipe_edge_in;
   logic [GRID_SIZE-1:0] row_vld_ff, row_vld_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_pixel_ff, rsp_pixel_in;
   logic                 rsp_clip_ff, rsp_clip_in;

   logic                 slot_free;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [GRID_SIZE-1:0] ram_q;
   logic [GRID_SIZE-1:0] old_row;
   logic [GRID_SIZE-1:0] set_mask;
   logic [GRID_SIZE-1:0] clr_mask;
   logic [GRID_SIZE-1:0] wr_data;

   bsde_ram #(
      .WIDTH (GRID_SIZE),
      .DEPTH (GRID_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (pipe_vld_ff),
      .wr_addr (pipe_row_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // rows never written since reset or clear read as zero
   assign old_row   = row_vld_ff[pipe_row_ff] ? ram_q : '0;
   assign set_mask  = pipe_edge_ff ? cmd_ff.edge_set[GRID_SIZE-1:0]
                                   : cmd_ff.mid_set[GRID_SIZE-1:0];
   assign clr_mask  = pipe_edge_ff ? '0 : cmd_ff.mid_clr[GRID_SIZE-1:0];
   assign wr_data   = (old_row & ~clr_mask) | set_mask;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cur_in       = cur_ff;
      pipe_vld_in  = 1'b0;
      pipe_row_in  = pipe_row_ff;
      pipe_edge_in = pipe_edge_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_clip_in  = rsp_clip_ff;
      cmd_pop      = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = cur_ff[AW-1:0];
      row_vld_in   = row_vld_ff;
      if (pipe_vld_ff) begin
         row_vld_in[pipe_row_ff] = 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && slot_free) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               unique case (cmd.kind)
                  KIND_CLEAR: begin
                     row_vld_in   = '0;
                     rsp_valid_in = 1'b1;
                     rsp_pixel_in = 1'b0;
                     rsp_clip_in  = 1'b0;
                  end
                  KIND_READ: begin
                     if (cmd.clip) begin
                        rsp_valid_in = 1'b1;
                        rsp_pixel_in = 1'b0;
                        rsp_clip_in  = 1'b1;
                     end else begin
                        rd_en       = 1'b1;
                        rd_addr     = cmd.row_lo[AW-1:0];
                        pipe_row_in = cmd.row_lo[AW-1:0];
                        state_in    = ST_READ;
                     end
                  end
                  KIND_DRAW: begin
                     if (cmd.row_lo < cmd.row_end) begin
                        cur_in   = cmd.row_lo;
                        state_in = ST_RUN;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_pixel_in = 1'b0;
                        rsp_clip_in  = cmd.clip;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_pixel_in = 1'b0;
                     rsp_clip_in  = 1'b0;
                  end
               endcase
            end
         end
         ST_RUN: begin
            // read this row, rewrite it in the following cycle
            rd_en        = 1'b1;
            rd_addr      = cur_ff[AW-1:0];
            pipe_vld_in  = 1'b1;
            pipe_row_in  = cur_ff[AW-1:0];
            pipe_edge_in = (cur_ff == cmd_ff.row_lo) || (cur_ff == cmd_ff.row_last);
            cur_in       = cur_ff + POS_W'(1);
            if (cur_in == cmd_ff.row_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            rsp_valid_in = 1'b1;
            rsp_pixel_in = 1'b0;
            rsp_clip_in  = cmd_ff.clip;
            state_in     = ST_IDLE;
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_pixel_in = |(old_row & cmd_ff.edge_set[GRID_SIZE-1:0]);
            rsp_clip_in  = 1'b0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pipe_vld_ff  <= 1'b0;
         row_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pipe_vld_ff  <= pipe_vld_in;
         row_vld_ff   <= row_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      cur_ff       <= cur_in;
      pipe_row_ff  <= pipe_row_in;
      pipe_edge_ff <= pipe_edge_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_clip_ff  <= rsp_clip_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_pixel_ff;
   assign rsp_clip  = rsp_clip_ff;

endmodule

`default_nettype wire

FILE: rtl/bitmap_shape_drawing_engine.sv
`default_nettype none

// bitmap_shape_drawing_engine: square one-bit-per-pixel bitmap driven by drawing commands
//
// req channel: one command word per handshake (clear, vertical or horizontal line,
// rectangle outline, filled rectangle, read pixel). rsp channel: exactly one result
// word per command, in command order, with the pixel read and a clipped flag for
// pixels that fell off the grid and were dropped.
// the front decodes each word into row span and column masks and pushes it into a
// two-entry command queue; req_tready drops only while that queue is full.
// the back pops one command at a time and does one row read-modify-write per cycle
// through the single-port-write bitmap ram: a draw steps through its grid rows in the
// run state and then the drain state, a read goes through the read state, and a clear,
// an unused code or a draw that covers no grid rows is answered straight from idle.
// each result is registered before it appears on rsp.
// reset empties the queue, drops any pending result and marks every bitmap row as
// zero at once (per-row valid bits), so there is no clearing sweep.
// when rsp_tready is low the result register holds; the back does not start the
// next command until the register is free, while the front keeps filling the queue.

module bitmap_shape_drawing_engine
   import bsde_pkg::*;
#(
   parameter int GRID_SIZE = GRID_SIZE_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // operation[2:0], start_row[7:3], start_col[12:8], length[18:13],
   // width[24:19], height[30:25], zero[31]
   input  wire logic [31:0] req_tdata,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // pixel_value[0], clipped[1], zero[7:2]
   output      logic [7:0]  rsp_tdata
);

   logic [OP_W-1:0]  req_operation;
   logic [RC_W-1:0]  req_start_row;
   logic [RC_W-1:0]  req_start_col;
   logic [EXT_W-1:0] req_length;
   logic [EXT_W-1:0] req_width;
   logic [EXT_W-1:0] req_height;

   cmd_type front_cmd;
   cmd_type head_cmd;
   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_valid;
   logic    rsp_pixel_value;
   logic    rsp_clipped;

   // unpack request word
   assign req_operation = req_tdata[2:0];
   assign req_start_row = req_tdata[7:3];
   assign req_start_col = req_tdata[12:8];
   assign req_length    = req_tdata[18:13];
   assign req_width     = req_tdata[24:19];
   assign req_height    = req_tdata[30:25];

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready;

   // decode into row span and column masks
   bsde_front #(
      .GRID_SIZE (GRID_SIZE)
   ) u_front (
      .operation (req_operation),
      .start_row (req_start_row),
      .start_col (req_start_col),
      .length    (req_length),
      .width     (req_width),
      .height    (req_height),
      .cmd       (front_cmd)
   );

   // decouples request intake from drawing
   bsde_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (front_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head_cmd (head_cmd)
   );

   // row-by-row drawing engine with the bitmap ram and result register
   bsde_back #(
      .GRID_SIZE (GRID_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd       (head_cmd),
      .cmd_pop   (q_pop),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_pixel (rsp_pixel_value),
      .rsp_clip  (rsp_clipped)
   );

   assign rsp_tdata = {6'b000000, rsp_clipped, rsp_pixel_value};

   // the back only takes a command that is present in the queue
   a_pop_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("command popped from empty queue");

   // a new command never starts while an untaken result would be overwritten
   a_pop_needs_slot: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!rsp_tvalid || rsp_tready))
      else $error("command started with result register occupied");

   // no result is pending right after reset
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a full queue is never pushed
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("push into full queue");

endmodule

`default_nettype wire

FILE: dv/tb_bitmap_shape_drawing_engine.sv
`timescale 1ns / 100ps

module tb_bitmap_shape_drawing_engine;
   import bsde_pkg::*;

   localparam int GRID = GRID_SIZE_DEF;

   // the two codes the block treats as no-ops
   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

   // time to keep watching for stray result words after the last one expected, covers a full draw
   localparam int TAIL_CYCLES = 2 * GRID + 8;
   // long receiver hold-off so the command queue fills and req_tready drops
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AT     = 300;

   typedef struct {
      logic [31:0] word;
      bit          drain_first;  // wait until every result is back before sending
   } cmd_word_type;

   typedef struct packed {
      logic pixel_value;
      logic clipped;
   } pixel_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // operation[2:0], start_row[7:3], start_col[12:8], length[18:13],
   // width[24:19], height[30:25], zero[31]
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // pixel_value[0], clipped[1], zero[7:2]
   logic [7:0]  rsp_tdata;

   // commands waiting for the driver and results waiting for the block
   cmd_word_type     cmd_backlog[$];
   pixel_result_type awaited_pixels[$];

   // private copy of the bitmap, bit c of row r is pixel (r, c)
   logic [GRID-1:0] canvas [GRID];

   cmd_word_type next_cmd;
   logic      req_taken = 1'b0;
   int        words_sent = 0;
   int        words_back = 0;
   int        error_count = 0;
   int        hold_left = 0;
   bit        hold_done = 1'b0;
   bit        calm;

   bitmap_shape_drawing_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // a stretch of the run with no idling on either side
   assign calm = (words_sent >= 700) && (words_sent < 900);

   // -----------------------------------------------------------------
   // predictor
   // -----------------------------------------------------------------

   // write one pixel, returns 1 when it lies off the grid and is dropped
   function automatic bit plot(input int row, input int col, input bit value);
      if (row >= GRID || col >= GRID) begin
         return 1'b1;
      end
      canvas[row][col] = value;
      return 1'b0;
   endfunction

   // apply one command word to the canvas and return the result it yields
   function automatic pixel_result_type paint_command(input logic [31:0] word);
      logic [OP_W-1:0] op;
      int            row, col, len, wid, hgt;
      bit            border;
      pixel_result_type res;
      op  = word[2:0];
      row = int'(word[7:3]);
      col = int'(word[12:8]);
      len = int'(word[18:13]);
      wid = int'(word[24:19]);
      hgt = int'(word[30:25]);
      res = '0;
      case (op)
         OP_CLEAR: begin
            for (int r = 0; r < GRID; r++) canvas[r] = '0;
         end
         OP_VLINE: begin
            for (int i = 0; i < len; i++) res.clipped |= plot(row + i, col, 1'b1);
         end
         OP_HLINE: begin
            for (int i = 0; i < len; i++) res.clipped |= plot(row, col + i, 1'b1);
         end
         OP_RECT, OP_FILL: begin
            for (int i = 0; i < hgt; i++) begin
               for (int j = 0; j < wid; j++) begin
                  border = (i == 0) || (j == 0) || (i == hgt - 1) || (j == wid - 1);
                  res.clipped |= plot(row + i, col + j, (op == OP_FILL) ? 1'b1 : border);
               end
            end
         end
         OP_READ: begin
            // row and column fit in five bits, so a read is always on the grid
            if (row < GRID && col < GRID) begin
               res.pixel_value = canvas[row][col];
            end else begin
               res.clipped = 1'b1;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // -----------------------------------------------------------------
   // stimulus helpers
   // -----------------------------------------------------------------

   function automatic logic [31:0] pack_cmd(input logic [OP_W-1:0] op, input int row,
                                            input int col, input int len,
                                            input int wid, input int hgt);
      logic [31:0] w;
      w        = '0;
      w[2:0]   = op;
      w[7:3]   = RC_W'(row);
      w[12:8]  = RC_W'(col);
      w[18:13] = EXT_W'(len);
      w[24:19] = EXT_W'(wid);
      w[30:25] = EXT_W'(hgt);
      return w;
   endfunction

   task automatic queue_cmd(input logic [31:0] word, input bit drain_first);
      cmd_word_type c;
      c.word        = word;
      c.drain_first = drain_first;
      cmd_backlog.push_back(c);
   endtask

   // mostly small extents so draws stay short, some full size, a few past the grid
   function automatic int pick_extent();
      int roll;
      roll = $urandom_range(99);
      if (roll < 75) return $urandom_range(12);
      if (roll < 95) return $urandom_range(GRID);
      return $urandom_range(63);
   endfunction

   // random command with realistic mix: mostly draws and reads on a live canvas
   function automatic logic [31:0] random_cmd();
      int              roll;
      logic [OP_W-1:0] op;
      roll = $urandom_range(99);
      if (roll < 4)       op = OP_CLEAR;
      else if (roll < 19) op = OP_VLINE;
      else if (roll < 34) op = OP_HLINE;
      else if (roll < 49) op = OP_RECT;
      else if (roll < 59) op = OP_FILL;
      else if (roll < 96) op = OP_READ;
      else                op = ($urandom_range(1) != 0) ? OP_SPARE_A : OP_SPARE_B;
      return pack_cmd(op, $urandom_range(GRID - 1), $urandom_range(GRID - 1),
                      pick_extent(), pick_extent(), pick_extent());
   endfunction

   // -----------------------------------------------------------------
   // driver: command words change on the falling edge
   // -----------------------------------------------------------------

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else if (!req_tvalid || req_taken) begin
         // only move on once the word on the bus has been taken
         if (cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= 19) &&
             (!cmd_backlog[0].drain_first || awaited_pixels.size() == 0)) begin
            next_cmd = cmd_backlog.pop_front();
            req_tdata  <= next_cmd.word;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // accepted command words update the canvas and queue what the block owes
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            awaited_pixels.push_back(paint_command(req_tdata));
            words_sent <= words_sent + 1;
         end
      end
   end

   // -----------------------------------------------------------------
   // receiver: random stalls plus one long hold-off
   // -----------------------------------------------------------------

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && words_back >= HOLD_AT) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 19);
      end
   end

   // -----------------------------------------------------------------
   // monitor: compare each result word with the oldest one owed
   // -----------------------------------------------------------------

   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_back <= words_back + 1;
         if (awaited_pixels.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("%0t: unexpected result word %h", $realtime, rsp_tdata);
            end
         end else begin
            want = awaited_pixels.pop_front();
            if (rsp_tdata[0] !== want.pixel_value || rsp_tdata[1] !== want.clipped) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("%0t: result %0d pixel_value exp %b got %b, clipped exp %b got %b",
                           $realtime, words_back, want.pixel_value, rsp_tdata[0],
                           want.clipped, rsp_tdata[1]);
               end
            end
         end
      end
   end

   // -----------------------------------------------------------------
   // stimulus and end of run
   // -----------------------------------------------------------------

   initial begin
      for (int r = 0; r < GRID; r++) canvas[r] = '0;

      // directed: edges of the grid, every operation, clipping and empty shapes
      queue_cmd(pack_cmd(OP_READ,  0,  0,  0,  0,  0), 1'b0);  // fresh bitmap is zero
      queue_cmd(pack_cmd(OP_VLINE, 0,  0, 32,  0,  0), 1'b0);  // full column, no clip
      queue_cmd(pack_cmd(OP_HLINE, 31, 0, 32,  0,  0), 1'b0);  // full bottom row
      queue_cmd(pack_cmd(OP_READ,  31, 31, 0,  0,  0), 1'b0);
      queue_cmd(pack_cmd(OP_VLINE, 31, 31, 63, 0,  0), 1'b0);  // runs off the bottom
      queue_cmd(pack_cmd(OP_HLINE, 0,  31, 63, 0,  0), 1'b0);  // runs off the right
      queue_cmd(pack_cmd(OP_VLINE, 7,  9,  0, 63, 63), 1'b0);  // zero length
      queue_cmd(pack_cmd(OP_RECT,  5,  5,  0, 10,  8), 1'b0);
      queue_cmd(pack_cmd(OP_READ,  5,  5,  0,  0,  0), 1'b0);  // on the border
      queue_cmd(pack_cmd(OP_READ,  6,  6,  0,  0,  0), 1'b0);  // interior
      queue_cmd(pack_cmd(OP_FILL,  20, 20, 0, 32, 32), 1'b0);  // clipped fill
      queue_cmd(pack_cmd(OP_READ,  25, 25, 0,  0,  0), 1'b0);
      queue_cmd(pack_cmd(OP_RECT,  0,  0,  0, 32, 32), 1'b0);  // clears the interior
      queue_cmd(pack_cmd(OP_READ,  25, 25, 0,  0,  0), 1'b0);
      queue_cmd(pack_cmd(OP_RECT,  12, 14, 0,  1,  1), 1'b0);  // single pixel box
      queue_cmd(pack_cmd(OP_RECT,  3,  3,  0,  0,  5), 1'b0);  // zero width
      queue_cmd(pack_cmd(OP_FILL,  31, 31, 0, 63, 63), 1'b0);  // mostly off the grid
      queue_cmd(pack_cmd(OP_RECT,  30, 0,  0,  2, 63), 1'b0);  // tall, clipped below
      queue_cmd(pack_cmd(OP_SPARE_A, 31, 31, 63, 63, 63), 1'b0);
      queue_cmd(pack_cmd(OP_SPARE_B, 17, 4, 21, 40, 9), 1'b0);
      queue_cmd(pack_cmd(OP_READ,  31, 31, 0,  0,  0), 1'b0);
      queue_cmd(pack_cmd(OP_CLEAR, 31, 31, 63, 63, 63), 1'b0);  // clear ignores fields
      queue_cmd(pack_cmd(OP_READ,  31, 31, 0,  0,  0), 1'b0);
      queue_cmd(pack_cmd(OP_READ,  0,  0,  0,  0,  0), 1'b0);

      // random part, with two points where the sender waits for the block to drain
      for (int n = 0; n < 1130; n++) begin
         queue_cmd(random_cmd(), (n == 0) || (n == 600));
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (cmd_backlog.size() != 0 || req_tvalid || awaited_pixels.size() != 0) begin
         @(posedge clock);
      end
      // any late or extra result word is caught by the monitor here
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && awaited_pixels.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // timeout far beyond the slowest correct run
   initial begin
      #(20_000_000);
      $display("timeout with %0d result words outstanding", awaited_pixels.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
